@@ sv/bcs_pkg.sv @@
// shared types and constants for the cubic bezier sampler
package bcs_pkg;

  // most samples taken from one segment
  localparam int unsigned MAX_SAMPLES = 63;

  // configuration register indexes
  localparam int unsigned REG_T_STEP = 0;

  // depths of the job queue and the result queue
  localparam int unsigned JOBQ_DEPTH = 2;
  localparam int unsigned OUTQ_DEPTH = 4;

  // kind of work handed from the front to the back
  typedef struct packed {
    logic has_seg;
    logic last;
  } job_flags_t;

  // sampler sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_LVL0,
    B_LVL1,
    B_LVL2,
    B_EMIT,
    B_END
  } back_state_t;

endpackage

@@ sv/bcs_front.sv @@
// front end: collects control points and turns closed segments into jobs
module bcs_front
  import bcs_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic                          last_point,
  output logic                          job_push,
  output logic [8*COORD_WIDTH-1:0]      job_pts,
  output job_flags_t                    job_flags
);

  logic [COORD_WIDTH-1:0] start_x, start_z;
  logic [COORD_WIDTH-1:0] ctrl_x [2];
  logic [COORD_WIDTH-1:0] ctrl_z [2];
  logic [1:0]             phase;
  logic                   started;
  logic                   closing;

  // a third point after the start closes a segment
  assign closing             = started && (phase == 2'd2);
  assign job_push            = accept && (last_point || closing);
  assign job_flags.has_seg   = closing;
  assign job_flags.last      = last_point;
  assign job_pts = {point_x, point_z, ctrl_x[1], ctrl_z[1], ctrl_x[0], ctrl_z[0],
                    start_x, start_z};

  // curve state
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_z <= '0;
      phase   <= 2'd0;
      started <= 1'b0;
    end else if (accept) begin
      if (!started) begin
        start_x <= point_x;
        start_z <= point_z;
        phase   <= 2'd0;
        started <= 1'b1;
      end else if (phase != 2'd2) begin
        phase <= phase + 2'd1;
      end else begin
        start_x <= point_x;
        start_z <= point_z;
        phase   <= 2'd0;
      end
      if (last_point) begin
        start_x <= '0;
        start_z <= '0;
        phase   <= 2'd0;
        started <= 1'b0;
      end
    end
  end

  // inner control points
  always_ff @(posedge clk) begin
    if (accept && started && (phase != 2'd2)) begin
      ctrl_x[phase[0]] <= point_x;
      ctrl_z[phase[0]] <= point_z;
    end
  end

endmodule

@@ sv/bcs_jobq.sv @@
// small queue of jobs between the front and the sampler
module bcs_jobq
  import bcs_pkg::*;
#(
  parameter int WIDTH = 194
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = $clog2(JOBQ_DEPTH);

  logic [WIDTH-1:0] mem [JOBQ_DEPTH];
  logic [AW-1:0]    wptr, rptr;
  logic [AW:0]      count;

  assign full  = (count == (AW+1)'(JOBQ_DEPTH));
  assign valid = (count != '0);
  assign rdata = mem[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) wptr <= wptr + 1'b1;
      if (pop && valid) rptr <= rptr + 1'b1;
      count <= count + (AW+1)'(push && !full) - (AW+1)'(pop && valid);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) mem[wptr] <= wdata;
  end

endmodule

@@ sv/bcs_back.sv @@
// back end: de casteljau sampling of each segment and the result queue
module bcs_back
  import bcs_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [T_FRAC_BITS:0]          t_step,
  input  logic                          job_valid,
  input  logic [8*COORD_WIDTH-1:0]      job_pts,
  input  job_flags_t                    job_flags,
  output logic                          job_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic                          is_end_point,
  output logic                          last_of_run
);

  localparam int CW       = COORD_WIDTH;
  localparam int TW       = T_FRAC_BITS + 2;
  localparam int PW       = CW + 1 + TW;
  localparam int T_ONE    = 1 << T_FRAC_BITS;
  localparam int MIN_STEP = (T_ONE + MAX_SAMPLES - 1) / MAX_SAMPLES;
  localparam int QW       = 2 * CW + 2;
  localparam int QA       = $clog2(OUTQ_DEPTH);

  back_state_t state, state_next;
  logic signed [CW-1:0] px [4];
  logic signed [CW-1:0] pz [4];
  logic signed [CW-1:0] wx [3];
  logic signed [CW-1:0] wz [3];
  logic signed [CW-1:0] lx [3];
  logic signed [CW-1:0] lz [3];
  job_flags_t           flags;
  logic [TW-1:0]        t, t_next, step;
  logic                 seg_done;

  // result queue
  logic [QW-1:0] q_mem [OUTQ_DEPTH];
  logic [QA-1:0] q_wptr, q_rptr;
  logic [QA:0]   q_count;
  logic          q_full, q_push;
  logic [QW-1:0] q_wdata;

  // step with the lower bound applied
  always_comb begin
    if ({1'b0, t_step} < TW'(MIN_STEP)) step = TW'(MIN_STEP);
    else step = {1'b0, t_step};
  end
  assign t_next   = t + step;
  assign seg_done = (t_next > TW'(T_ONE));

  // three lerp lanes per coordinate, sources picked by level
  always_comb begin
    logic signed [CW-1:0] ax, bx, az, bz;
    logic signed [CW:0]   dx, dz;
    logic signed [PW-1:0] mx, mz;
    for (int j = 0; j < 3; j++) begin
      if (state == B_LVL0) begin
        ax = px[j]; bx = px[j+1];
        az = pz[j]; bz = pz[j+1];
      end else begin
        ax = wx[j]; bx = (j < 2) ? wx[(j+1) % 3] : px[3];
        az = wz[j]; bz = (j < 2) ? wz[(j+1) % 3] : pz[3];
      end
      dx = {bx[CW-1], bx} - {ax[CW-1], ax};
      dz = {bz[CW-1], bz} - {az[CW-1], az};
      mx = PW'(dx) * $signed({1'b0, t});
      mz = PW'(dz) * $signed({1'b0, t});
      mx = mx >>> T_FRAC_BITS;
      mz = mz >>> T_FRAC_BITS;
      lx[j] = ax + mx[CW-1:0];
      lz[j] = az + mz[CW-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (job_valid) state_next = job_flags.has_seg ? B_LVL0 : B_END;
      B_LVL0: state_next = B_LVL1;
      B_LVL1: state_next = B_LVL2;
      B_LVL2: state_next = B_EMIT;
      B_EMIT: begin
        if (!q_full) begin
          if (!seg_done) state_next = B_LVL0;
          else state_next = flags.last ? B_END : B_IDLE;
        end
      end
      B_END:  if (!q_full) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    job_pop = 1'b0;
    q_push  = 1'b0;
    q_wdata = {px[3], pz[3], 1'b1, 1'b1};
    case (state)
      B_IDLE: job_pop = job_valid;
      B_EMIT: begin
        q_push  = !q_full;
        q_wdata = {wx[0], wz[0], 1'b0, seg_done && !flags.last};
      end
      B_END:  q_push = !q_full;
      default: ;
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  // job points, parameter and partial sums
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        t     <= '0;
        flags <= job_flags;
        for (int j = 0; j < 4; j++) begin
          pz[j] <= job_pts[2*j*CW +: CW];
          px[j] <= job_pts[(2*j+1)*CW +: CW];
        end
      end
      B_LVL0, B_LVL1, B_LVL2: begin
        for (int j = 0; j < 3; j++) begin
          wx[j] <= lx[j];
          wz[j] <= lz[j];
        end
      end
      B_EMIT: if (!q_full) t <= t_next;
      default: ;
    endcase
  end

  // result queue
  assign q_full       = (q_count == (QA+1)'(OUTQ_DEPTH));
  assign empty        = (q_count == '0);
  assign out_x        = q_mem[q_rptr][QW-1 -: CW];
  assign out_z        = q_mem[q_rptr][2 +: CW];
  assign is_end_point = q_mem[q_rptr][1];
  assign last_of_run  = q_mem[q_rptr][0];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wptr  <= '0;
      q_rptr  <= '0;
      q_count <= '0;
    end else begin
      if (q_push) q_wptr <= q_wptr + 1'b1;
      if (pop && !empty) q_rptr <= q_rptr + 1'b1;
      q_count <= q_count + (QA+1)'(q_push) - (QA+1)'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) q_mem[q_wptr] <= q_wdata;
  end

  // checks
  a_t_range: assert property (@(posedge clk) disable iff (rst)
    (state == B_LVL0) |-> (t <= TW'(T_ONE)))
    else $error("sample parameter beyond one");
  a_lvl_order: assert property (@(posedge clk) disable iff (rst)
    (state == B_LVL1) |-> ($past(state) == B_LVL0))
    else $error("level two without level one");
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= (QA+1)'(OUTQ_DEPTH))
    else $error("result queue overflow");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> (state == B_IDLE && job_valid))
    else $error("job taken while busy");

endmodule

@@ sv/piecewise_cubic_bezier_sampler.sv @@
// top level of the piecewise cubic bezier sampler
// a control point is taken while the job queue has room
// a closing point's job is picked up in the idle state; each sample then passes through
// the three lerp levels and the emit step of the sampler sequencer, and the emit step
// waits while the result queue is full; the end point copy is queued from the end state
// synchronous reset clears curve state, queues and sequencer; t_step returns to one sixteenth
module piecewise_cubic_bezier_sampler
  import bcs_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic                          last_point,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic                          is_end_point,
  output logic                          last_of_run,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [1:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int JW = 8 * COORD_WIDTH + $bits(job_flags_t);

  logic [T_FRAC_BITS:0]       t_step;
  logic                       accept;
  logic                       f_push, jq_full, jq_valid, jq_pop;
  logic [8*COORD_WIDTH-1:0]   f_pts, b_pts;
  job_flags_t                 f_flags, b_flags;
  logic [JW-1:0]              jq_rdata;

  // configuration port
  assign pready = 1'b1;
  assign prdata = 32'(t_step);

  always_ff @(posedge clk) begin
    if (rst) t_step <= (T_FRAC_BITS+1)'(1 << (T_FRAC_BITS - 4));
    else if (psel && penable && pwrite && (paddr[1:0] >> 2) == REG_T_STEP[1:0])
      t_step <= pwdata[T_FRAC_BITS:0];
  end

  // input transaction
  assign full   = jq_full;
  assign accept = push && !jq_full;

  bcs_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .point_x    (point_x),
    .point_z    (point_z),
    .last_point (last_point),
    .job_push   (f_push),
    .job_pts    (f_pts),
    .job_flags  (f_flags)
  );

  bcs_jobq #(.WIDTH(JW)) u_jobq (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata ({f_pts, f_flags}),
    .full  (jq_full),
    .pop   (jq_pop),
    .valid (jq_valid),
    .rdata (jq_rdata)
  );

  assign b_pts   = jq_rdata[JW-1 -: 8*COORD_WIDTH];
  assign b_flags = jq_rdata[$bits(job_flags_t)-1:0];

  bcs_back #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .t_step       (t_step),
    .job_valid    (jq_valid),
    .job_pts      (b_pts),
    .job_flags    (b_flags),
    .job_pop      (jq_pop),
    .empty        (empty),
    .pop          (pop),
    .out_x        (out_x),
    .out_z        (out_z),
    .is_end_point (is_end_point),
    .last_of_run  (last_of_run)
  );

endmodule

@@ bench/bcs_checker.sv @@
// checker for the cubic bezier sampler: predicts curve samples and compares results
module bcs_checker
  import bcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic signed [23:0] point_x,
  input  logic signed [23:0] point_z,
  input  logic               last_point,
  input  logic               empty,
  input  logic               pop,
  input  logic signed [23:0] out_x,
  input  logic signed [23:0] out_z,
  input  logic               is_end_point,
  input  logic               last_of_run,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen,
  output int                 end_points_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint T_ONE = 65536;
  localparam longint MIN_STEP = (T_ONE + MAX_SAMPLES - 1) / MAX_SAMPLES;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] z;
    logic               endp;
    logic               last;
  } curve_pt_t;

  curve_pt_t expected_pts[$];

  // model state
  logic [16:0] step_reg;
  longint seg_x, seg_z;
  longint inner_x[2], inner_z[2];
  int     n_inner;
  bit     have_start;

  function automatic longint lerp(longint a, longint b, longint t);
    longint p;
    p = (b - a) * t;
    return a + (p >>> 16);
  endfunction

  function automatic longint de_casteljau(longint p0, longint p1, longint p2, longint p3,
                                          longint t);
    longint a, b, c;
    a = lerp(p0, p1, t);
    b = lerp(p1, p2, t);
    c = lerp(p2, p3, t);
    a = lerp(a, b, t);
    b = lerp(b, c, t);
    return lerp(a, b, t);
  endfunction

  task automatic predict_point(longint px, longint pz, bit last);
    curve_pt_t pt;
    longint step, t;
    int n, first;
    first = expected_pts.size();
    n = 0;
    if (!have_start) begin
      seg_x = px; seg_z = pz; n_inner = 0; have_start = 1;
    end else if (n_inner < 2) begin
      inner_x[n_inner] = px; inner_z[n_inner] = pz; n_inner++;
    end else begin
      step = step_reg;
      if (step < MIN_STEP) step = MIN_STEP;
      for (t = 0; t <= T_ONE && n < MAX_SAMPLES; t += step) begin
        pt.x = de_casteljau(seg_x, inner_x[0], inner_x[1], px, t);
        pt.z = de_casteljau(seg_z, inner_z[0], inner_z[1], pz, t);
        pt.endp = 0; pt.last = 0;
        expected_pts = {expected_pts, pt};
        n++;
      end
      seg_x = px; seg_z = pz; n_inner = 0;
    end
    if (last) begin
      pt.x = px; pt.z = pz; pt.endp = 1; pt.last = 0;
      expected_pts = {expected_pts, pt};
      have_start = 0; n_inner = 0; seg_x = 0; seg_z = 0;
    end
    if (expected_pts.size() > first) expected_pts[$].last = 1;
  endtask

  // watch register writes, input and result transactions
  always @(posedge clk) begin
    curve_pt_t exp_pt;
    if (rst) begin
      step_reg <= 17'd4096;
      have_start = 0; n_inner = 0; seg_x = 0; seg_z = 0;
      expected_pts.delete();
      fail_count <= 0; results_seen <= 0; end_points_seen <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 2'(REG_T_STEP * 4))
        step_reg <= pwdata[16:0];
      if (push && !full) predict_point(point_x, point_z, last_point);
      if (pop && !empty) begin
        results_seen <= results_seen + 1;
        if (is_end_point) end_points_seen <= end_points_seen + 1;
        if (expected_pts.size() == 0) begin
          $display("%0t: unexpected result x=%0d z=%0d", $time, out_x, out_z);
          fail_count <= fail_count + 1;
        end else begin
          exp_pt = expected_pts.pop_front();
          if (exp_pt.x !== out_x || exp_pt.z !== out_z || exp_pt.endp !== is_end_point ||
              exp_pt.last !== last_of_run) begin
            $display("%0t: mismatch expected x=%0d z=%0d end=%0b last=%0b",
                     $time, exp_pt.x, exp_pt.z, exp_pt.endp, exp_pt.last);
            $display("%0t:          got x=%0d z=%0d end=%0b last=%0b",
                     $time, out_x, out_z, is_end_point, last_of_run);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending = expected_pts.size();
  end

endmodule

@@ bench/tb_piecewise_cubic_bezier_sampler.sv @@
// testbench top: stimulus, register writes and verdict for the bezier sampler
module tb_piecewise_cubic_bezier_sampler
  import bcs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  logic push, full, last_point, empty, pop;
  logic signed [23:0] point_x, point_z, out_x, out_z;
  logic is_end_point, last_of_run;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  int fail_count, pending, results_seen, end_points_seen;
  int points_sent;
  bit hold_off;

  piecewise_cubic_bezier_sampler u_top (.*);

  bcs_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("FAILURE");
    $finish;
  end

  // write the parameter step register over the apb port
  task automatic write_step(logic [31:0] value);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= 2'(REG_T_STEP * 4); pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // one input transaction followed by a random gap
  task automatic send_point(logic signed [23:0] x, logic signed [23:0] z, logic last);
    int gap;
    push <= 1; point_x <= x; point_z <= z; last_point <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    points_sent++;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return 24'sh7fffff;
      1: return 24'sh800000;
      2: return 24'(signed'($urandom_range(0, 2000)) - 1000);
      default: return 24'($urandom);
    endcase
  endfunction

  // send a curve of n points, the last flagged
  task automatic send_curve(int n);
    for (int i = 0; i < n; i++) send_point(rand_coord(), rand_coord(), i == n - 1);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // result side: random pop stalls plus one long hold-off
  initial begin
    int gap;
    pop <= 0;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        pop <= 0;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        pop <= 0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  initial begin
    logic [31:0] steps[6] = '{0, 1041, 4096, 65536, 65537, 32'h1ffff};
    push = 0; point_x = 0; point_z = 0; last_point = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    points_sent = 0; hold_off = 0;
    rst = 1;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset step, single point, partial segments, extremes
    send_point(24'sh7fffff, 24'sh800000, 1);
    send_curve(2);
    send_curve(3);
    send_point(24'sh800000, 24'sh7fffff, 0);
    send_point(24'sh7fffff, 24'sh800000, 0);
    send_point(24'sh800000, 24'sh7fffff, 0);
    send_point(24'sh7fffff, 24'sh800000, 0);
    send_point(0, 0, 0);
    send_point(-1, -1, 1);
    push <= 0;
    drain();

    // long receiver stall while points keep coming, enough to fill the job queue
    hold_off = 1;
    send_curve(16);
    push <= 0;
    drain();

    // random curves over several step settings, extremes among them
    for (int s = 0; s < 6; s++) begin
      write_step(s == 5 ? 32'($urandom_range(1041, 65536)) | 32'hfffe0000 : steps[s]);
      while (points_sent < 28 + 42 * (s + 1)) begin
        if ($urandom_range(0, 9) == 0) send_curve($urandom_range(1, 3));
        else send_curve(3 * $urandom_range(1, 3) + 1);
      end
      push <= 0;
      drain();
    end

    $display("covered %0d points, %0d results, %0d end points, six step settings",
             points_sent, results_seen, end_points_seen);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/bcs_pkg.sv
sv/bcs_front.sv
sv/bcs_jobq.sv
sv/bcs_back.sv
sv/piecewise_cubic_bezier_sampler.sv
bench/bcs_checker.sv
bench/tb_piecewise_cubic_bezier_sampler.sv
